// File: sv/pie_pkg.sv
// shared constants for the pagerank iteration engine
`timescale 1ns / 1ps

package pie_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int DEG_W   = 14;
    localparam int RANK_W  = 32;
    localparam int DAMP_W  = 17;
    localparam int DSUM_W  = 33;
    localparam int PROD_W  = RANK_W + DAMP_W;
    localparam int DIV_W   = 34;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int CIDX_W  = 2;

    localparam logic [DEG_W-1:0]  DEG_MAX   = '1;
    localparam logic [DAMP_W-1:0] DAMP_ONE  = DAMP_W'(65536);
    localparam logic [DAMP_W-1:0] DAMP_RST  = DAMP_W'(55706);
    localparam logic [NCNT_W-1:0] NODES_RST = NCNT_W'(MAX_NODES);
    localparam logic [DIV_W-1:0]  ONE_Q31   = DIV_W'(64'h8000_0000);

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_INIT = 2'd1,
        OP_RUN  = 2'd2,
        OP_READ = 2'd3
    } t_op;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_NODES = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DAMP  = 2'd1;

endpackage

// File: sv/pagerank_iteration_engine_core.sv
// pagerank power iteration engine: edge store, degree, rank memories and sequencer
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// input     in         i_valid / o_ready         i_opcode, i_source_node, i_target_node
// output    out        o_valid / i_ready         o_status, o_node_index, o_rank_value
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one transaction at a time; the shared one-bit-a-cycle divider serves init, each live edge
// of a run and the teleport share of a run, and a run also sweeps the nodes twice; stale edges
// are skipped without a division
// after reset a clearing pass over all 1024 entries zeroes the degree memory; no input taken then
// a finished result moves to the output register, so the next transaction may be taken
// while the previous result is still stalled downstream; config writes are always taken

module pagerank_iteration_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pie_pkg::OP_W-1:0]     i_opcode,
    input  logic [pie_pkg::NODE_W-1:0]   i_source_node,
    input  logic [pie_pkg::NODE_W-1:0]   i_target_node,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pie_pkg::ST_W-1:0]     o_status,
    output logic [pie_pkg::NODE_W-1:0]   o_node_index,
    output logic [pie_pkg::RANK_W-1:0]   o_rank_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pie_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [pie_pkg::DAMP_W-1:0]   i_cfg_data
);

    typedef enum logic [16:0] {
        S_CLR     = 17'h00001,
        S_IDLE    = 17'h00002,
        S_ADD     = 17'h00004,
        S_INITDIV = 17'h00008,
        S_INITWR  = 17'h00010,
        S_SUM     = 17'h00020,
        S_ERD     = 17'h00040,
        S_ENODE   = 17'h00080,
        S_EMUL    = 17'h00100,
        S_EDSTART = 17'h00200,
        S_EDIV    = 17'h00400,
        S_EADD    = 17'h00800,
        S_TM1     = 17'h01000,
        S_TM2     = 17'h02000,
        S_TDIV    = 17'h04000,
        S_COPY    = 17'h08000,
        S_RD      = 17'h10000
    } t_state;

    // memories
    logic [2*pie_pkg::NODE_W-1:0] edge_mem [pie_pkg::MAX_EDGES];
    logic [pie_pkg::DEG_W-1:0]    deg_mem  [pie_pkg::MAX_NODES];
    logic [pie_pkg::RANK_W-1:0]   rank_mem [pie_pkg::MAX_NODES];
    logic [pie_pkg::RANK_W-1:0]   next_mem [pie_pkg::MAX_NODES];

    logic                         edge_we;
    logic [pie_pkg::EADDR_W-1:0]  edge_wa, edge_ra;
    logic [2*pie_pkg::NODE_W-1:0] edge_wd, edge_rd;
    logic                         deg_we;
    logic [pie_pkg::NODE_W-1:0]   deg_wa, deg_ra;
    logic [pie_pkg::DEG_W-1:0]    deg_wd, deg_rd;
    logic                         rank_we;
    logic [pie_pkg::NODE_W-1:0]   rank_wa, rank_ra;
    logic [pie_pkg::RANK_W-1:0]   rank_wd, rank_rd;
    logic                         next_we;
    logic [pie_pkg::NODE_W-1:0]   next_wa, next_ra;
    logic [pie_pkg::RANK_W-1:0]   next_wd, next_rd;

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_rd <= edge_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_wa] <= deg_wd;
        end
        deg_rd <= deg_mem[deg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_rd <= rank_mem[rank_ra];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd <= next_mem[next_ra];
    end

    // control and datapath registers
    t_state                        r_state, n_state;
    logic [pie_pkg::NCNT_W-1:0]    r_n, n_n;
    logic [pie_pkg::DAMP_W-1:0]    r_damp, n_damp;
    logic [pie_pkg::ECNT_W-1:0]    r_ecnt, n_ecnt;
    logic [pie_pkg::ECNT_W-1:0]    r_eidx, n_eidx;
    logic [pie_pkg::NCNT_W-1:0]    r_idx, n_idx;
    logic                          r_pvld, n_pvld;
    logic [pie_pkg::NODE_W-1:0]    r_pidx, n_pidx;
    logic [pie_pkg::NODE_W-1:0]    r_src, n_src;
    logic [pie_pkg::NODE_W-1:0]    r_et, n_et;
    logic [pie_pkg::DSUM_W-1:0]    r_dsum, n_dsum;
    logic [pie_pkg::PROD_W-1:0]    r_prod, n_prod;
    logic [pie_pkg::RANK_W-1:0]    r_nxt, n_nxt;
    logic [pie_pkg::ST_W-1:0]      r_res_st, n_res_st;
    logic [pie_pkg::RANK_W-1:0]    r_res_rank, n_res_rank;
    logic                          r_done, n_done;
    logic                          r_o_vld, n_o_vld;
    logic [pie_pkg::ST_W-1:0]      r_o_st, n_o_st;
    logic [pie_pkg::NODE_W-1:0]    r_o_idx, n_o_idx;
    logic [pie_pkg::RANK_W-1:0]    r_o_rank, n_o_rank;

    // shared restoring divider, one quotient bit a cycle
    logic                          r_div_busy, n_div_busy;
    logic [pie_pkg::DIV_W-1:0]     r_div_q, n_div_q;
    logic [pie_pkg::DEG_W-1:0]     r_div_rem, n_div_rem;
    logic [pie_pkg::DEG_W-1:0]     r_div_den, n_div_den;
    logic [pie_pkg::DCNT_W-1:0]    r_div_cnt, n_div_cnt;

    logic [pie_pkg::DEG_W:0]       div_t;
    logic                          div_ge;
    logic                          in_acc;
    logic                          src_ok, tgt_ok;
    logic [pie_pkg::NODE_W-1:0]    e_s, e_t;
    logic [pie_pkg::DSUM_W:0]      dsum_add;
    logic [pie_pkg::PROD_W:0]      tele_prod;
    logic [pie_pkg::DIV_W-1:0]     tele_num;
    logic [pie_pkg::RANK_W+2:0]    sat_sum;
    logic [pie_pkg::NCNT_W-1:0]    cfg_n;
    logic [pie_pkg::DAMP_W-1:0]    cfg_d;

    assign o_cfg_ready  = 1'b1;
    assign o_ready      = (r_state == S_IDLE) && !r_done;
    assign o_valid      = r_o_vld;
    assign o_status     = r_o_st;
    assign o_node_index = r_o_idx;
    assign o_rank_value = r_o_rank;

    assign in_acc = i_valid && o_ready;
    assign src_ok = {1'b0, i_source_node} < r_n;
    assign tgt_ok = {1'b0, i_target_node} < r_n;
    assign e_s    = edge_rd[2*pie_pkg::NODE_W-1:pie_pkg::NODE_W];
    assign e_t    = edge_rd[pie_pkg::NODE_W-1:0];

    assign div_t  = {r_div_rem, r_div_q[pie_pkg::DIV_W-1]};
    assign div_ge = div_t >= {1'b0, r_div_den};

    // config clamps
    always_comb begin
        cfg_n = i_cfg_data[pie_pkg::NCNT_W-1:0];
        if (cfg_n == '0) begin
            cfg_n = pie_pkg::NCNT_W'(1);
        end else if (cfg_n > pie_pkg::NODES_RST) begin
            cfg_n = pie_pkg::NODES_RST;
        end
        cfg_d = i_cfg_data;
        if (cfg_d > pie_pkg::DAMP_ONE) begin
            cfg_d = pie_pkg::DAMP_ONE;
        end
    end

    always_comb begin
        // defaults
        n_state    = r_state;
        n_n        = r_n;
        n_damp     = r_damp;
        n_ecnt     = r_ecnt;
        n_eidx     = r_eidx;
        n_idx      = r_idx;
        n_pvld     = 1'b0;
        n_pidx     = r_pidx;
        n_src      = r_src;
        n_et       = r_et;
        n_dsum     = r_dsum;
        n_prod     = r_prod;
        n_nxt      = r_nxt;
        n_res_st   = r_res_st;
        n_res_rank = r_res_rank;
        n_done     = r_done;
        n_o_vld    = r_o_vld;
        n_o_st     = r_o_st;
        n_o_idx    = r_o_idx;
        n_o_rank   = r_o_rank;
        n_div_busy = r_div_busy;
        n_div_q    = r_div_q;
        n_div_rem  = r_div_rem;
        n_div_den  = r_div_den;
        n_div_cnt  = r_div_cnt;

        edge_we = 1'b0;
        edge_wa = r_ecnt[pie_pkg::EADDR_W-1:0];
        edge_wd = {i_source_node, i_target_node};
        edge_ra = r_eidx[pie_pkg::EADDR_W-1:0];
        deg_we  = 1'b0;
        deg_wa  = r_src;
        deg_wd  = '0;
        deg_ra  = r_idx[pie_pkg::NODE_W-1:0];
        rank_we = 1'b0;
        rank_wa = r_idx[pie_pkg::NODE_W-1:0];
        rank_wd = r_div_q[pie_pkg::RANK_W-1:0];
        rank_ra = r_idx[pie_pkg::NODE_W-1:0];
        next_we = 1'b0;
        next_wa = r_idx[pie_pkg::NODE_W-1:0];
        next_wd = '0;
        next_ra = r_idx[pie_pkg::NODE_W-1:0];

        dsum_add  = {1'b0, r_dsum} + (pie_pkg::DSUM_W+1)'(rank_rd);
        tele_prod = (pie_pkg::PROD_W+1)'(r_prod)
                  + ((pie_pkg::PROD_W+1)'(r_dsum[pie_pkg::DSUM_W-1] ? r_damp : '0) << 32);
        tele_num  = pie_pkg::DIV_W'(tele_prod >> 16)
                  + (pie_pkg::DIV_W'(pie_pkg::DAMP_ONE - r_damp) << 15);
        sat_sum   = '0;

        // configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                pie_pkg::CFG_NODES: n_n    = cfg_n;
                pie_pkg::CFG_DAMP:  n_damp = cfg_d;
                default: ;
            endcase
        end

        // divider step
        if (r_div_busy) begin
            n_div_rem = div_ge ? pie_pkg::DEG_W'(div_t - {1'b0, r_div_den})
                               : div_t[pie_pkg::DEG_W-1:0];
            n_div_q   = {r_div_q[pie_pkg::DIV_W-2:0], div_ge};
            n_div_cnt = r_div_cnt + 1'b1;
            if (r_div_cnt == pie_pkg::DCNT_W'(pie_pkg::DIV_W - 1)) begin
                n_div_busy = 1'b0;
            end
        end

        // output register, refilled from the finished result
        if (r_o_vld && i_ready) begin
            n_o_vld = 1'b0;
        end
        if (r_done && (!r_o_vld || i_ready)) begin
            n_o_vld  = 1'b1;
            n_o_st   = r_res_st;
            n_o_idx  = r_src;
            n_o_rank = r_res_rank;
            n_done   = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                deg_we = 1'b1;
                deg_wa = r_idx[pie_pkg::NODE_W-1:0];
                n_idx  = r_idx + 1'b1;
                if (r_idx == pie_pkg::NCNT_W'(pie_pkg::MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                deg_ra  = i_source_node;
                rank_ra = i_source_node;
                if (in_acc) begin
                    n_src      = i_source_node;
                    n_res_st   = pie_pkg::ST_OK;
                    n_res_rank = '0;
                    case (pie_pkg::t_op'(i_opcode))
                        pie_pkg::OP_ADD: begin
                            if (!src_ok || !tgt_ok) begin
                                n_res_st = pie_pkg::ST_RANGE;
                                n_done   = 1'b1;
                            end else if (r_ecnt == pie_pkg::ECNT_W'(pie_pkg::MAX_EDGES)) begin
                                n_res_st = pie_pkg::ST_FULL;
                                n_done   = 1'b1;
                            end else begin
                                edge_we = 1'b1;
                                n_ecnt  = r_ecnt + 1'b1;
                                n_state = S_ADD;
                            end
                        end
                        pie_pkg::OP_INIT: begin
                            n_div_busy = 1'b1;
                            n_div_q    = pie_pkg::ONE_Q31;
                            n_div_rem  = '0;
                            n_div_den  = pie_pkg::DEG_W'(r_n);
                            n_div_cnt  = '0;
                            n_state    = S_INITDIV;
                        end
                        pie_pkg::OP_RUN: begin
                            n_idx   = '0;
                            n_dsum  = '0;
                            n_state = S_SUM;
                        end
                        pie_pkg::OP_READ: begin
                            if (!src_ok) begin
                                n_res_st = pie_pkg::ST_RANGE;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                // degree read-modify-write, saturating
                deg_we = deg_rd != pie_pkg::DEG_MAX;
                deg_wd = deg_rd + 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                n_res_rank = rank_rd;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            S_INITDIV: begin
                n_idx = '0;
                if (!r_div_busy) begin
                    n_state = S_INITWR;
                end
            end
            S_INITWR: begin
                if (r_idx < r_n) begin
                    rank_we = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                // dangling sum and clearing of the next-rank store, one node a cycle
                if (r_idx < r_n) begin
                    next_we = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_pvld  = 1'b1;
                end
                if (r_pvld && deg_rd == '0) begin
                    n_dsum = dsum_add[pie_pkg::DSUM_W] ? '1 : dsum_add[pie_pkg::DSUM_W-1:0];
                end
                if (r_idx == r_n && !r_pvld) begin
                    n_eidx  = '0;
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                if (r_eidx == r_ecnt) begin
                    n_state = S_TM1;
                end else begin
                    n_state = S_ENODE;
                end
            end
            S_ENODE: begin
                rank_ra = e_s;
                deg_ra  = e_s;
                next_ra = e_t;
                n_et    = e_t;
                if ({1'b0, e_s} >= r_n || {1'b0, e_t} >= r_n) begin
                    n_eidx  = r_eidx + 1'b1;
                    n_state = S_ERD;
                end else begin
                    n_state = S_EMUL;
                end
            end
            S_EMUL: begin
                n_prod    = rank_rd * r_damp;
                n_div_den = deg_rd;
                n_nxt     = next_rd;
                if (deg_rd == '0) begin
                    n_eidx  = r_eidx + 1'b1;
                    n_state = S_ERD;
                end else begin
                    n_state = S_EDSTART;
                end
            end
            S_EDSTART: begin
                n_div_busy = 1'b1;
                n_div_q    = pie_pkg::DIV_W'(r_prod >> 16);
                n_div_rem  = '0;
                n_div_cnt  = '0;
                n_state    = S_EDIV;
            end
            S_EDIV: begin
                if (!r_div_busy) begin
                    n_state = S_EADD;
                end
            end
            S_EADD: begin
                sat_sum = (pie_pkg::RANK_W+3)'(r_nxt) + (pie_pkg::RANK_W+3)'(r_div_q);
                next_we = 1'b1;
                next_wa = r_et;
                next_wd = (sat_sum > (pie_pkg::RANK_W+3)'({pie_pkg::RANK_W{1'b1}}))
                        ? '1 : sat_sum[pie_pkg::RANK_W-1:0];
                n_eidx  = r_eidx + 1'b1;
                n_state = S_ERD;
            end
            S_TM1: begin
                n_prod  = r_dsum[pie_pkg::RANK_W-1:0] * r_damp;
                n_state = S_TM2;
            end
            S_TM2: begin
                // teleport share: (damping*dsum/2^16 + (1-damping)*2^15) / N
                n_div_busy = 1'b1;
                n_div_q    = tele_num;
                n_div_rem  = '0;
                n_div_den  = pie_pkg::DEG_W'(r_n);
                n_div_cnt  = '0;
                n_state    = S_TDIV;
            end
            S_TDIV: begin
                n_idx = '0;
                if (!r_div_busy) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                // next plus teleport into the rank store
                if (r_idx < r_n) begin
                    n_idx  = r_idx + 1'b1;
                    n_pvld = 1'b1;
                    n_pidx = r_idx[pie_pkg::NODE_W-1:0];
                end
                sat_sum = (pie_pkg::RANK_W+3)'(next_rd) + (pie_pkg::RANK_W+3)'(r_div_q);
                rank_we = r_pvld;
                rank_wa = r_pidx;
                rank_wd = (sat_sum > (pie_pkg::RANK_W+3)'({pie_pkg::RANK_W{1'b1}}))
                        ? '1 : sat_sum[pie_pkg::RANK_W-1:0];
                if (r_idx == r_n && !r_pvld) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_n        <= pie_pkg::NODES_RST;
            r_damp     <= pie_pkg::DAMP_RST;
            r_ecnt     <= '0;
            r_idx      <= '0;
            r_pvld     <= 1'b0;
            r_done     <= 1'b0;
            r_o_vld    <= 1'b0;
            r_div_busy <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_damp     <= n_damp;
            r_ecnt     <= n_ecnt;
            r_idx      <= n_idx;
            r_pvld     <= n_pvld;
            r_done     <= n_done;
            r_o_vld    <= n_o_vld;
            r_div_busy <= n_div_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx     <= n_eidx;
        r_pidx     <= n_pidx;
        r_src      <= n_src;
        r_et       <= n_et;
        r_dsum     <= n_dsum;
        r_prod     <= n_prod;
        r_nxt      <= n_nxt;
        r_res_st   <= n_res_st;
        r_res_rank <= n_res_rank;
        r_o_st     <= n_o_st;
        r_o_idx    <= n_o_idx;
        r_o_rank   <= n_o_rank;
        r_div_q    <= n_div_q;
        r_div_rem  <= n_div_rem;
        r_div_den  <= n_div_den;
        r_div_cnt  <= n_div_cnt;
    end

endmodule

// File: tb/sv/pagerank_iteration_engine_core_tb.sv
// self-checking testbench for the pagerank iteration engine core
`timescale 1ns / 1ps

module pagerank_iteration_engine_core_tb;

    // idle cycles with no transaction on any channel before giving up;
    // the limit is set high enough to cover a run over a full edge store
    localparam int IDLE_LIMIT = 2000000;
    localparam int LONG_HOLD  = 400;
    // keep random edge loads small so that runs stay cheap
    localparam int EDGE_SOFT_CAP = 300;

    typedef struct packed {
        pie_pkg::t_op                  op;
        logic [pie_pkg::NODE_W-1:0]    src;
        logic [pie_pkg::NODE_W-1:0]    dst;
    } t_req;

    typedef struct packed {
        logic [pie_pkg::ST_W-1:0]      status;
        logic [pie_pkg::NODE_W-1:0]    node;
        logic [pie_pkg::RANK_W-1:0]    rank;
    } t_reply;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [pie_pkg::OP_W-1:0]        i_opcode = '0;
    logic [pie_pkg::NODE_W-1:0]      i_source_node = '0;
    logic [pie_pkg::NODE_W-1:0]      i_target_node = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [pie_pkg::ST_W-1:0]        o_status;
    logic [pie_pkg::NODE_W-1:0]      o_node_index;
    logic [pie_pkg::RANK_W-1:0]      o_rank_value;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [pie_pkg::CIDX_W-1:0]      i_cfg_index = '0;
    logic [pie_pkg::DAMP_W-1:0]      i_cfg_data = '0;

    pagerank_iteration_engine_core dut (.*);

    always #10 i_clk = ~i_clk;

    // shadow state of the engine, advanced at each accepted input transaction
    int unsigned                   nodes_in_use = pie_pkg::MAX_NODES;
    int unsigned                   alpha_q16 = 55706;
    logic [pie_pkg::NODE_W-1:0]    edge_src_mem [pie_pkg::MAX_EDGES];
    logic [pie_pkg::NODE_W-1:0]    edge_dst_mem [pie_pkg::MAX_EDGES];
    int unsigned                   edges_stored = 0;
    logic [pie_pkg::DEG_W-1:0]     degree_mem [pie_pkg::MAX_NODES];
    logic [pie_pkg::RANK_W-1:0]    rank_mem [pie_pkg::MAX_NODES];
    logic [pie_pkg::RANK_W-1:0]    next_rank_mem [pie_pkg::MAX_NODES];

    t_reply rank_replies [$];   // expected result transactions, oldest first
    t_req   pending_reqs [$];   // stimulus not yet offered
    int     err_count = 0;

    // stimulus-side bookkeeping, done at generation time
    int unsigned gen_edges = 0;
    int unsigned gen_nodes = pie_pkg::MAX_NODES;
    bit          idle_on = 1'b1;
    bit          hold_start = 1'b0;
    int          hold_cnt = 0;

    task automatic report(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic logic [pie_pkg::RANK_W-1:0] sat_sum(
        input logic [pie_pkg::RANK_W-1:0] a, input longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > 64'hFFFF_FFFF) ? '1 : s[pie_pkg::RANK_W-1:0];
    endfunction

    // one damped power-iteration step over the shadow memories
    task automatic power_step();
        longint unsigned dangling;
        longint unsigned teleport;
        longint unsigned a;
        int unsigned s, t;
        dangling = 0;
        a = alpha_q16;
        for (int i = 0; i < nodes_in_use; i++) begin
            if (degree_mem[i] == 0) begin
                dangling += rank_mem[i];
                if (dangling > 64'h1_FFFF_FFFF) dangling = 64'h1_FFFF_FFFF;
            end
            next_rank_mem[i] = '0;
        end
        for (int e = 0; e < edges_stored; e++) begin
            s = edge_src_mem[e];
            t = edge_dst_mem[e];
            // edges left behind by a shrunk node count are skipped
            if (s >= nodes_in_use || t >= nodes_in_use || degree_mem[s] == 0) continue;
            next_rank_mem[t] = sat_sum(next_rank_mem[t],
                (longint'(rank_mem[s]) * a) / (longint'(degree_mem[s]) * 65536));
        end
        teleport = (a * dangling + (65536 - a) * 64'h8000_0000)
                   / (longint'(nodes_in_use) * 65536);
        for (int i = 0; i < nodes_in_use; i++)
            rank_mem[i] = sat_sum(next_rank_mem[i], teleport);
    endtask

    task automatic step_pagerank(input t_req r);
        t_reply rep;
        rep.status = pie_pkg::ST_OK;
        rep.node = r.src;
        rep.rank = '0;
        case (r.op)
            pie_pkg::OP_ADD: begin
                // range test wins over the full test
                if (r.src >= nodes_in_use || r.dst >= nodes_in_use) begin
                    rep.status = pie_pkg::ST_RANGE;
                end else if (edges_stored >= pie_pkg::MAX_EDGES) begin
                    rep.status = pie_pkg::ST_FULL;
                end else begin
                    edge_src_mem[edges_stored] = r.src;
                    edge_dst_mem[edges_stored] = r.dst;
                    edges_stored++;
                    if (degree_mem[r.src] != pie_pkg::DEG_MAX) degree_mem[r.src]++;
                end
            end
            pie_pkg::OP_INIT: begin
                for (int i = 0; i < nodes_in_use; i++)
                    rank_mem[i] = 32'h8000_0000 / nodes_in_use;
            end
            pie_pkg::OP_RUN: power_step();
            default: begin
                if (r.src >= nodes_in_use) rep.status = pie_pkg::ST_RANGE;
                else rep.rank = rank_mem[r.src];
            end
        endcase
        rank_replies.push_back(rep);
    endtask

    // input driver: gap drawn per transaction, payload held until accepted
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_req nx;
        int   g;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            g = gap_left;
            if (i_valid && o_ready) begin
                step_pagerank(t_req'({pie_pkg::t_op'(i_opcode), i_source_node,
                                      i_target_node}));
                g = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (!i_valid || o_ready) begin
                if (g > 0) begin
                    i_valid <= 1'b0;
                    g--;
                end else if (pending_reqs.size() > 0) begin
                    nx = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= nx.op;
                    i_source_node <= nx.src;
                    i_target_node <= nx.dst;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            gap_left <= g;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_start && hold_cnt == 0) hold_cnt <= LONG_HOLD;
        else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    // output monitor with random back-pressure
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_reply want;
        int     s;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            s = stall_left;
            if (o_valid && i_ready) begin
                if (rank_replies.size() == 0) begin
                    report($sformatf("unexpected result node %0d", o_node_index));
                end else begin
                    want = rank_replies.pop_front();
                    if (o_status !== want.status)
                        report($sformatf("status %0d, want %0d (node %0d)",
                                         o_status, want.status, want.node));
                    if (o_node_index !== want.node)
                        report($sformatf("node %0d, want %0d", o_node_index, want.node));
                    if (o_rank_value !== want.rank)
                        report($sformatf("rank %0h, want %0h (node %0d)",
                                         o_rank_value, want.rank, want.node));
                end
                s = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (hold_cnt > 0) begin
                i_ready <= 1'b0;
            end else if (s > 0) begin
                i_ready <= 1'b0;
                s--;
            end else begin
                i_ready <= 1'b1;
            end
            stall_left <= s;
        end
    end

    // watchdog on cycles without any transaction
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_req(input pie_pkg::t_op op, input int src, input int dst);
        t_req r;
        r.op = op;
        r.src = pie_pkg::NODE_W'(src);
        r.dst = pie_pkg::NODE_W'(dst);
        if (op == pie_pkg::OP_ADD && src < gen_nodes && dst < gen_nodes) gen_edges++;
        pending_reqs.push_back(r);
    endtask

    // sampled away from the rising edge so that the driver has settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || rank_replies.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    // register write, only with the engine drained
    task automatic write_reg(input logic [pie_pkg::CIDX_W-1:0] idx, input int unsigned val);
        int unsigned v;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[pie_pkg::DAMP_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == pie_pkg::CFG_NODES) begin
            v = val & 32'h7FF;
            if (v == 0) v = 1;
            if (v > pie_pkg::MAX_NODES) v = pie_pkg::MAX_NODES;
            nodes_in_use = v;
            gen_nodes = v;
        end else begin
            v = val & 32'h1FFFF;
            alpha_q16 = (v > 65536) ? 65536 : v;
        end
    endtask

    task automatic set_up(input int unsigned n, input int unsigned a);
        wait_drained();
        write_reg(pie_pkg::CFG_NODES, n);
        write_reg(pie_pkg::CFG_DAMP, a);
        queue_req(pie_pkg::OP_INIT, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    function automatic int any_node();
        // mostly in range, sometimes anywhere in the field
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
        return $urandom_range(0, gen_nodes - 1);
    endfunction

    task automatic random_burst(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55 && gen_edges < EDGE_SOFT_CAP)
                queue_req(pie_pkg::OP_ADD, any_node(), any_node());
            else if (pick < 90 || pick >= 55 && pick < 55)
                queue_req(pie_pkg::OP_READ, any_node(), $urandom_range(0, 1023));
            else if (pick < 95)
                queue_req(pie_pkg::OP_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                queue_req(pie_pkg::OP_INIT, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    initial begin
        int unsigned n_pick, a_pick;
        for (int i = 0; i < pie_pkg::MAX_NODES; i++) begin
            degree_mem[i] = '0;
            rank_mem[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extreme nodes, every opcode
        queue_req(pie_pkg::OP_INIT, 1023, 0);
        queue_req(pie_pkg::OP_READ, 0, 1023);
        queue_req(pie_pkg::OP_READ, 1023, 0);
        queue_req(pie_pkg::OP_ADD, 0, 1023);
        queue_req(pie_pkg::OP_ADD, 1023, 0);
        queue_req(pie_pkg::OP_ADD, 5, 5);
        queue_req(pie_pkg::OP_RUN, 0, 0);
        queue_req(pie_pkg::OP_READ, 0, 0);
        queue_req(pie_pkg::OP_READ, 1023, 1023);

        // tiny graph, undamped; old edges on node 1023 go stale
        set_up(4, 65536);
        queue_req(pie_pkg::OP_ADD, 3, 3);
        queue_req(pie_pkg::OP_ADD, 4, 0);
        queue_req(pie_pkg::OP_ADD, 0, 4);
        queue_req(pie_pkg::OP_ADD, 1023, 1023);
        queue_req(pie_pkg::OP_READ, 1023, 0);
        queue_req(pie_pkg::OP_READ, 3, 0);
        queue_req(pie_pkg::OP_RUN, 0, 0);
        queue_req(pie_pkg::OP_READ, 0, 0);

        // zero node count is taken as one, damping zero
        set_up(32'h1F800, 0);
        queue_req(pie_pkg::OP_RUN, 0, 0);
        queue_req(pie_pkg::OP_READ, 0, 0);
        queue_req(pie_pkg::OP_READ, 1, 0);

        // oversize writes clamp to the maximum
        set_up(2047, 131071);
        queue_req(pie_pkg::OP_RUN, 0, 0);
        queue_req(pie_pkg::OP_READ, 512, 0);

        // random phases through a spread of settings
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 4))
                0: n_pick = $urandom_range(1, 3);
                1, 2: n_pick = $urandom_range(1, 64);
                3: n_pick = $urandom_range(65, 1024);
                default: n_pick = 1024;
            endcase
            case ($urandom_range(0, 3))
                0: a_pick = 0;
                1: a_pick = 65536 + $urandom_range(0, 65535);
                default: a_pick = $urandom_range(0, 65536);
            endcase
            set_up(n_pick, a_pick);
            idle_on = (ph % 3 != 2);
            if (ph == 1) begin
                // receiver holds off while the sender keeps offering
                @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            random_burst(50);
            if (ph == 4) wait_drained();
            random_burst(50);
        end
        idle_on = 1'b1;

        // shrink the node count, then run over the stale edges
        set_up(1024, 55706);
        queue_req(pie_pkg::OP_ADD, 1023, 1023);
        queue_req(pie_pkg::OP_ADD, 0, 0);
        set_up(16, 55706);
        queue_req(pie_pkg::OP_ADD, 20, 1);
        queue_req(pie_pkg::OP_RUN, 0, 0);
        for (int i = 0; i < 4; i++) queue_req(pie_pkg::OP_READ, $urandom_range(0, 31), 0);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/pie_pkg.sv
sv/pagerank_iteration_engine_core.sv
tb/sv/pagerank_iteration_engine_core_tb.sv
